// ===== hdl/alst_pkg.sv =====
// Package for the array list engine: field widths, action and status codes,
// and the command, result and stored-record types.
// Depends on nothing; every other file of the block but alst_stream_if imports it.
package alst_pkg;

    localparam int DEF_LIST_DEPTH = 128;

    localparam int ACTION_W = 4;
    localparam int POS_W    = 8;
    localparam int KEY_W    = 32;
    localparam int NAME_W   = 64;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 7;
    localparam int COUNT_W  = 8;

    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_FIRST  = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_LAST   = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_INS_BEFORE = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_INS_AFTER  = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_DEL_FIRST  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_DEL_LAST   = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_DEL_AT     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_SEARCH     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_READ       = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name_bytes;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FPOS_W-1:0]   found_position;
        logic [KEY_W-1:0]    found_key;
        logic [NAME_W-1:0]   found_name;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
    } t_rec;

endpackage

// ===== hdl/alst_stream_if.sv =====
// Valid/ready stream interface used for the command and result channels.
// The payload type is a parameter; no package dependency.
interface alst_stream_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/array_list_engine_core.sv =====
// Channel   Dir  Beat payload                                  Handshake
// i_cmd     in   action, position, key, name_bytes             valid/ready
// o_rsp     out  status, found_position, found_key,            valid/ready
//                found_name, entry_count
//
// One command is worked at a time. An insert moves the entries from the last
// down to the landing slot one slot higher, then writes the record; a delete
// moves the entries above the position one lower; a search reads entries in
// order until the key matches or the list ends; a read fetches one entry. The
// single read port of the store sets that pace; the result then reaches the
// output register. Reset is synchronous and empties the list; the store keeps
// its contents. A stalled result waits in the output register while the next
// command is accepted and worked; only its own result then waits for the slot.
module array_list_engine_core #(
    parameter int LIST_DEPTH = alst_pkg::DEF_LIST_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alst_stream_if.sink   i_cmd,
    alst_stream_if.source o_rsp
);
    import alst_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);

    logic          res_valid;
    t_rsp          res;
    logic          slot_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_rec          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_rec          rd_data;
    logic          r_out_valid;
    t_rsp          r_out;

    assign slot_free = !r_out_valid || o_rsp.ready;

    alst_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (slot_free),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    alst_mem #(
        .DEPTH (LIST_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid && slot_free) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

// ===== hdl/alst_mem.sv =====
// Record store of the array list engine: one write port, one read port,
// read data registered. Depends on alst_pkg for the record type.
module alst_mem #(
    parameter int DEPTH = alst_pkg::DEF_LIST_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  alst_pkg::t_rec  i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output alst_pkg::t_rec  o_rd_data
);
    import alst_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/alst_ctrl.sv =====
// Sequencer of the array list engine: decodes a command, shifts entries
// through the record store one per cycle, scans for keys and builds the result.
// Depends on alst_pkg and alst_stream_if.
module alst_ctrl #(
    parameter int LIST_DEPTH = alst_pkg::DEF_LIST_DEPTH,
    localparam int AW = $clog2(LIST_DEPTH),
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    alst_stream_if.sink     i_cmd,
    output logic            o_res_valid,
    output alst_pkg::t_rsp  o_res,
    input  logic            i_res_ready,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output alst_pkg::t_rec  o_wr_data,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  alst_pkg::t_rec  i_rd_data
);
    import alst_pkg::*;

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHUP,
        S_PUT,
        S_SHDN,
        S_SRCH,
        S_READ,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_at, n_at;
    t_rec            r_rec, n_rec;
    t_rsp            r_res, n_res;

    t_cmd            cmd;
    logic            accept;
    logic            full;
    logic            empty;
    logic [AW-1:0]   last;
    logic [XW-1:0]   cnt_x;
    logic [XW-1:0]   pos_x;

    assign cmd    = i_cmd.payload;
    assign i_cmd.ready = (r_state == S_IDLE) && i_rst_n;
    assign accept = i_cmd.valid && i_cmd.ready;
    assign full   = (r_count == CW'(LIST_DEPTH));
    assign empty  = (r_count == '0);
    assign last   = AW'(r_count - 1'b1);
    assign cnt_x  = XW'(r_count);
    assign pos_x  = XW'(cmd.position);

    always_comb begin
        logic          is_ins;
        logic          is_del;
        logic          bad;
        logic [XW-1:0] at_x;
        logic [AW-1:0] at;

        n_state   = r_state;
        n_count   = r_count;
        n_src     = r_src;
        n_at      = r_at;
        n_rec     = r_rec;
        n_res     = r_res;
        o_wr_en   = 1'b0;
        o_wr_addr = r_src;
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_src;
        is_ins    = 1'b0;
        is_del    = 1'b0;
        bad       = 1'b0;
        at_x      = '0;
        at        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res        = '0;
                    n_res.status = ST_OK;
                    n_rec.key    = cmd.key;
                    n_rec.name   = cmd.name_bytes;
                    n_state      = S_DONE;
                    unique case (cmd.action)
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_INS_FIRST: begin
                            is_ins = 1'b1;
                        end
                        ACT_INS_LAST: begin
                            is_ins = 1'b1;
                            at_x   = cnt_x;
                        end
                        ACT_INS_BEFORE: begin
                            is_ins = 1'b1;
                            bad    = (pos_x > cnt_x);
                            at_x   = pos_x;
                        end
                        ACT_INS_AFTER: begin
                            is_ins = 1'b1;
                            bad    = (pos_x >= cnt_x);
                            at_x   = pos_x + 1'b1;
                        end
                        ACT_DEL_FIRST: begin
                            is_del = 1'b1;
                        end
                        ACT_DEL_LAST: begin
                            is_del = 1'b1;
                            at_x   = XW'(last);
                        end
                        ACT_DEL_AT: begin
                            is_del = 1'b1;
                            bad    = (pos_x >= cnt_x);
                            at_x   = pos_x;
                        end
                        ACT_SEARCH: begin
                            if (empty) begin
                                n_res.status = ST_NOTFOUND;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_src     = '0;
                                n_state   = S_SRCH;
                            end
                        end
                        ACT_READ: begin
                            if (empty) begin
                                n_res.status = ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                n_res.status = ST_BADPOS;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(cmd.position);
                                n_src     = AW'(cmd.position);
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase

                    at = AW'(at_x);
                    if (is_ins) begin
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else if (bad) begin
                            n_res.status = ST_BADPOS;
                        end else if (at_x == cnt_x) begin
                            // Appending needs no shift: write the record now.
                            o_wr_en   = 1'b1;
                            o_wr_addr = at;
                            o_wr_data = n_rec;
                            n_count   = CW'(r_count + 1'b1);
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = last;
                            n_src     = last;
                            n_at      = at;
                            n_state   = S_SHUP;
                        end
                    end
                    if (is_del) begin
                        if (empty) begin
                            n_res.status = ST_EMPTY;
                        end else if (bad) begin
                            n_res.status = ST_BADPOS;
                        end else if (at == last) begin
                            n_count = CW'(r_count - 1'b1);
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = AW'(at + 1'b1);
                            n_src     = AW'(at + 1'b1);
                            n_state   = S_SHDN;
                        end
                    end
                end
            end

            // Moving up: the entry read last cycle lands one slot higher while
            // the next lower one is read. Reads stay below the write pointer.
            S_SHUP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_src + 1'b1);
                o_wr_data = i_rd_data;
                if (r_src == r_at) begin
                    n_state = S_PUT;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(r_src - 1'b1);
                    n_src     = AW'(r_src - 1'b1);
                end
            end

            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_at;
                o_wr_data = r_rec;
                n_count   = CW'(r_count + 1'b1);
                n_state   = S_DONE;
            end

            S_SHDN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_src - 1'b1);
                o_wr_data = i_rd_data;
                if (r_src == last) begin
                    n_count = CW'(r_count - 1'b1);
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(r_src + 1'b1);
                    n_src     = AW'(r_src + 1'b1);
                end
            end

            S_SRCH: begin
                if (i_rd_data.key == r_rec.key) begin
                    n_res.status         = ST_OK;
                    n_res.found_position = FPOS_W'(r_src);
                    n_res.found_key      = i_rd_data.key;
                    n_res.found_name     = i_rd_data.name;
                    n_state              = S_DONE;
                end else if (r_src == last) begin
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(r_src + 1'b1);
                    n_src     = AW'(r_src + 1'b1);
                end
            end

            S_READ: begin
                n_res.found_position = FPOS_W'(r_src);
                n_res.found_key      = i_rd_data.key;
                n_res.found_name     = i_rd_data.name;
                n_state              = S_DONE;
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_state == S_DONE && r_state != S_DONE) begin
            n_res.entry_count = COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_at  <= n_at;
        r_rec <= n_rec;
        r_res <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== hdl/alst_chk.sv =====
// Port-level checks for the array list engine, bound to the top level.
// Depends on alst_pkg for the result type and status codes.
module alst_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cmd_valid,
    input logic           i_cmd_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input alst_pkg::t_rsp i_rsp_payload
);
    import alst_pkg::*;

    // Commands accepted whose result beat has not yet gone out.
    logic [2:0] r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= 3'(r_open + {2'b00, i_cmd_valid && i_cmd_ready}
                      - {2'b00, i_rsp_valid && i_rsp_ready});
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("result beat changed or dropped while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_payload.status != ST_OK |->
            i_rsp_payload.found_position == '0 && i_rsp_payload.found_key == '0
            && i_rsp_payload.found_name == '0)
        else $error("failed action reports a found entry");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_open != 3'd0)
        else $error("result beat without an accepted command");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 3'd2)
        else $error("more than two commands outstanding");

endmodule

bind array_list_engine_core alst_chk u_alst_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
